### rtl/core/rmv_pkg.sv
// Shared types, constants and the control program of the running mean/variance block.
// No dependencies; imported by rmv_seq, rmv_dp and running_mean_variance_top.
package rmv_pkg;

    // fixed field widths
    localparam int SAMPLE_BITS   = 16;
    localparam int VAR_BITS      = 50;
    localparam int MEAN_OUT_BITS = 32;
    localparam int CNT_OUT_BITS  = 16;
    localparam int OUT_DATA_BITS = 104;
    localparam int PC_BITS       = 4;

    typedef logic [3:0]         t_op;
    typedef logic [1:0]         t_len;
    typedef logic [2:0]         t_br;
    typedef logic [PC_BITS-1:0] t_pc;

    // datapath operations
    localparam t_op OP_NOP    = 4'd0;
    localparam t_op OP_TAKE   = 4'd1;  // latch sample, update count, restart clear
    localparam t_op OP_LOAD_M = 4'd2;  // load divider with |x - mean| / n
    localparam t_op OP_DIV    = 4'd3;  // one restoring division step
    localparam t_op OP_MEAN   = 4'd4;  // apply mean step, load (S + n-2) / (n-1)
    localparam t_op OP_DEC    = 4'd5;  // decay term, load q * q
    localparam t_op OP_MUL    = 4'd6;  // one shift-add multiply step
    localparam t_op OP_SQ     = 4'd7;  // truncate square, load sq * n
    localparam t_op OP_VAR    = 4'd8;  // saturating variance sum
    localparam t_op OP_OUT    = 4'd9;  // load output word

    // loop length selects
    localparam t_len LEN_NONE = 2'd0;
    localparam t_len LEN_MEAN = 2'd1;
    localparam t_len LEN_VAR  = 2'd2;
    localparam t_len LEN_CNT  = 2'd3;

    // branch kinds
    localparam t_br BR_NEXT     = 3'd0;
    localparam t_br BR_WAIT_IN  = 3'd1;
    localparam t_br BR_LOOP     = 3'd2;
    localparam t_br BR_FIRST    = 3'd3;
    localparam t_br BR_WAIT_OUT = 3'd4;
    localparam t_br BR_JUMP     = 3'd5;

    // program addresses used as jump targets
    localparam t_pc PC_START = 4'd0;
    localparam t_pc PC_OUT   = 4'd10;

    typedef struct packed {
        t_op  op;
        t_len len_sel;
        t_br  br;
        t_pc  target;
    } t_uword;

    // sequencer to datapath
    typedef struct packed {
        t_op op;
    } t_ctl;

    // datapath to sequencer
    typedef struct packed {
        logic first;     // count below two: no variance update
        logic out_free;  // output register can take a word
    } t_sts;

    // control program
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        case (pc)
            4'd0:    w = '{OP_TAKE,   LEN_NONE, BR_WAIT_IN,  PC_START};
            4'd1:    w = '{OP_LOAD_M, LEN_MEAN, BR_NEXT,     PC_START};
            4'd2:    w = '{OP_DIV,    LEN_NONE, BR_LOOP,     PC_START};
            4'd3:    w = '{OP_MEAN,   LEN_VAR,  BR_FIRST,    PC_OUT};
            4'd4:    w = '{OP_DIV,    LEN_NONE, BR_LOOP,     PC_START};
            4'd5:    w = '{OP_DEC,    LEN_MEAN, BR_NEXT,     PC_START};
            4'd6:    w = '{OP_MUL,    LEN_NONE, BR_LOOP,     PC_START};
            4'd7:    w = '{OP_SQ,     LEN_CNT,  BR_NEXT,     PC_START};
            4'd8:    w = '{OP_MUL,    LEN_NONE, BR_LOOP,     PC_START};
            4'd9:    w = '{OP_VAR,    LEN_NONE, BR_NEXT,     PC_START};
            4'd10:   w = '{OP_OUT,    LEN_NONE, BR_WAIT_OUT, PC_START};
            default: w = '{OP_NOP,    LEN_NONE, BR_JUMP,     PC_START};
        endcase
        return w;
    endfunction

endpackage

### rtl/core/rmv_seq.sv
// Microcode sequencer: program counter, loop counter and branch logic.
// Depends on rmv_pkg for the control word layout and the program table.
module rmv_seq #(
    parameter int COUNT_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  rmv_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output rmv_pkg::t_ctl o_ctl
);
    import rmv_pkg::*;

    localparam int W_M   = SAMPLE_BITS + FRAC_BITS;
    localparam int W_V   = VAR_BITS + 1;
    localparam int L_MV  = (W_M > W_V) ? W_M : W_V;
    localparam int L_MAX = (L_MV > COUNT_BITS) ? L_MV : COUNT_BITS;
    localparam int CNT_W = $clog2(L_MAX + 1);

    t_pc               r_pc;
    t_pc               n_pc;
    logic [CNT_W-1:0]  r_lcnt;
    logic [CNT_W-1:0]  n_lcnt;
    t_uword            uw;
    logic              hold;

    assign uw = ucode(r_pc);

    // a waiting step issues no operation
    assign hold       = ((uw.br == BR_WAIT_IN) && !i_in_valid) ||
                        ((uw.br == BR_WAIT_OUT) && !i_sts.out_free);
    assign o_in_ready = (uw.br == BR_WAIT_IN);
    assign o_ctl.op   = hold ? OP_NOP : uw.op;

    // next step
    always_comb begin
        n_pc = r_pc + t_pc'(1);
        case (uw.br)
            BR_NEXT:     n_pc = r_pc + t_pc'(1);
            BR_WAIT_IN:  if (!i_in_valid) n_pc = r_pc;
            BR_LOOP:     if (r_lcnt != CNT_W'(1)) n_pc = r_pc;
            BR_FIRST:    if (i_sts.first) n_pc = uw.target;
            BR_WAIT_OUT: n_pc = i_sts.out_free ? uw.target : r_pc;
            BR_JUMP:     n_pc = uw.target;
            default:     n_pc = PC_START;
        endcase
    end

    // loop counter: loaded by setup steps, counted down by loop steps
    always_comb begin
        n_lcnt = r_lcnt;
        if (uw.br == BR_LOOP) begin
            n_lcnt = r_lcnt - CNT_W'(1);
        end else begin
            case (uw.len_sel)
                LEN_MEAN: n_lcnt = CNT_W'(W_M);
                LEN_VAR:  n_lcnt = CNT_W'(W_V);
                LEN_CNT:  n_lcnt = CNT_W'(COUNT_BITS);
                default:  n_lcnt = r_lcnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= PC_START;
            r_lcnt <= '0;
        end else begin
            r_pc   <= n_pc;
            r_lcnt <= n_lcnt;
        end
    end

endmodule

### rtl/core/rmv_dp.sv
// Datapath: mean/variance state, shared restoring divider, shift-add multiplier, output word.
// Depends on rmv_pkg; driven step by step by rmv_seq.
module rmv_dp #(
    parameter int COUNT_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rmv_pkg::t_ctl                       i_ctl,
    output rmv_pkg::t_sts                       o_sts,
    input  logic [rmv_pkg::SAMPLE_BITS-1:0]     i_sample,
    input  logic                                i_restart,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [rmv_pkg::OUT_DATA_BITS-1:0]   o_out_data
);
    import rmv_pkg::*;

    localparam int W_M   = SAMPLE_BITS + FRAC_BITS;       // mean width
    localparam int W_V   = VAR_BITS + 1;                  // decay dividend width
    localparam int W_N   = (W_M > W_V) ? W_M : W_V;       // divider shift register
    localparam int W_P2  = 2 * W_M;
    localparam int W_PN  = 2 * W_M - FRAC_BITS + COUNT_BITS;
    localparam int W_P   = (W_P2 > W_PN) ? W_P2 : W_PN;   // product width
    localparam int W_R   = (W_M > COUNT_BITS) ? W_M : COUNT_BITS;
    localparam int W_E   = (W_M > MEAN_OUT_BITS + 1) ? W_M : MEAN_OUT_BITS + 1;
    localparam int W_CE  = (COUNT_BITS > CNT_OUT_BITS) ? COUNT_BITS : CNT_OUT_BITS;
    localparam int PAD   = OUT_DATA_BITS - MEAN_OUT_BITS - VAR_BITS - CNT_OUT_BITS;

    localparam logic signed [W_E-1:0] MO_MAX = W_E'((64'sd1 <<< (MEAN_OUT_BITS - 1)) - 1);
    localparam logic signed [W_E-1:0] MO_MIN = -MO_MAX - W_E'(1);

    // architectural state
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [W_M-1:0]         r_mean;
    logic [VAR_BITS-1:0]           r_var;
    logic [COUNT_BITS-1:0]         r_cnt;
    // working registers
    logic                          r_neg;
    logic [W_M-1:0]                r_q;
    logic [VAR_BITS-1:0]           r_dec;
    logic [W_N-1:0]                r_dvd;
    logic [COUNT_BITS-1:0]         r_rem;
    logic [COUNT_BITS-1:0]         r_dvs;
    logic [W_P-1:0]                r_mcand;
    logic [W_R-1:0]                r_mplr;
    logic [W_P-1:0]                r_acc;
    logic                          r_ovalid;
    logic [OUT_DATA_BITS-1:0]      r_odata;

    logic signed [W_M-1:0]         xs;
    logic signed [W_M:0]           d;
    logic [W_M:0]                  d_mag;
    logic [COUNT_BITS:0]           rem_sh;
    logic                          ge;
    logic [COUNT_BITS:0]           rem_sub;
    logic [W_M-1:0]                q_now;
    logic [W_V-1:0]                vdiv;
    logic [VAR_BITS:0]             vsum;
    logic                          vsat;
    logic signed [W_E-1:0]         mean_ext;
    logic [MEAN_OUT_BITS-1:0]      mean_out;
    logic [W_CE-1:0]               cnt_ext;

    // mean difference and magnitude
    assign xs    = {r_x, {FRAC_BITS{1'b0}}};
    assign d     = {xs[W_M-1], xs} - {r_mean[W_M-1], r_mean};
    assign d_mag = d[W_M] ? (~d + 1'b1) : d;

    // restoring divider step
    assign rem_sh  = {r_rem, r_dvd[W_N-1]};
    assign ge      = (rem_sh >= {1'b0, r_dvs});
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign q_now   = r_dvd[W_M-1:0];

    // S + n - 2 for the rounded-up decay quotient
    assign vdiv = {1'b0, r_var} + W_V'(r_cnt) - W_V'(2);

    // growth plus decay, saturating
    assign vsum = {1'b0, r_dec} + {1'b0, r_acc[VAR_BITS-1:0]};
    assign vsat = (|r_acc[W_P-1:VAR_BITS]) || vsum[VAR_BITS];

    // output clamp and count truncation
    assign mean_ext = W_E'(r_mean);
    always_comb begin
        if (mean_ext > MO_MAX) begin
            mean_out = MO_MAX[MEAN_OUT_BITS-1:0];
        end else if (mean_ext < MO_MIN) begin
            mean_out = MO_MIN[MEAN_OUT_BITS-1:0];
        end else begin
            mean_out = mean_ext[MEAN_OUT_BITS-1:0];
        end
    end
    assign cnt_ext = W_CE'(r_cnt);

    assign o_sts.first    = (r_cnt < COUNT_BITS'(2));
    assign o_sts.out_free = !r_ovalid || i_out_ready;
    assign o_out_valid    = r_ovalid;
    assign o_out_data     = r_odata;

    // state that reset clears
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean   <= '0;
            r_var    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_ctl.op == OP_OUT) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (i_ctl.op)
                OP_TAKE: begin
                    if (i_restart) begin
                        r_mean <= '0;
                        r_var  <= '0;
                        r_cnt  <= COUNT_BITS'(1);
                    end else if (r_cnt != {COUNT_BITS{1'b1}}) begin
                        r_cnt <= r_cnt + COUNT_BITS'(1);
                    end
                end
                OP_MEAN: begin
                    r_mean <= r_neg ? (r_mean - q_now) : (r_mean + q_now);
                    if (o_sts.first) r_var <= '0;
                end
                OP_VAR: begin
                    r_var <= vsat ? {VAR_BITS{1'b1}} : vsum[VAR_BITS-1:0];
                end
                default: ;
            endcase
        end
    end

    // working registers, no reset
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_TAKE: begin
                r_x <= i_sample;
            end
            OP_LOAD_M: begin
                r_neg <= d[W_M];
                r_dvd <= W_N'(d_mag[W_M-1:0]) << (W_N - W_M);
                r_rem <= '0;
                r_dvs <= r_cnt;
            end
            OP_DIV: begin
                r_dvd <= {r_dvd[W_N-2:0], ge};
                r_rem <= ge ? rem_sub[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
            end
            OP_MEAN: begin
                r_q   <= q_now;
                r_dvd <= W_N'(vdiv) << (W_N - W_V);
                r_rem <= '0;
                r_dvs <= r_cnt - COUNT_BITS'(1);
            end
            OP_DEC: begin
                r_dec   <= r_var - r_dvd[VAR_BITS-1:0];
                r_mcand <= W_P'(r_q);
                r_mplr  <= W_R'(r_q);
                r_acc   <= '0;
            end
            OP_MUL: begin
                if (r_mplr[0]) r_acc <= r_acc + r_mcand;
                r_mcand <= r_mcand << 1;
                r_mplr  <= r_mplr >> 1;
            end
            OP_SQ: begin
                r_mcand <= r_acc >> FRAC_BITS;
                r_mplr  <= W_R'(r_cnt);
                r_acc   <= '0;
            end
            OP_OUT: begin
                r_odata <= {{PAD{1'b0}}, cnt_ext[CNT_OUT_BITS-1:0], r_var, mean_out};
            end
            default: ;
        endcase
    end

endmodule

### rtl/core/running_mean_variance_top.sv
// Top level of the running mean and sample variance block.
// Depends on rmv_pkg, rmv_seq (microcode sequencer) and rmv_dp (datapath).
//
// Usage:
//   Slave stream s_axis_*: one word per signed 16-bit sample; tuser carries the
//   restart flag, which clears count, mean and variance before the sample.
//   Master stream m_axis_*: one word per sample with the updated mean
//   (signed, FRAC_BITS fraction bits, clamped to 32 bits), the sample variance
//   (50 bits, saturating) and the sample count.
//   A step program in rmv_pkg runs one division step or one multiply step per
//   cycle through a shared divider and a shift-add multiplier.
//   Every sample runs the mean division loop; a sample that updates the variance
//   also runs the decay division loop and both multiply loops, while the first
//   sample after restart goes straight to the output step. No new sample is
//   accepted before the program is back at its first step; s_axis_tready is
//   high only while the program waits at its first step.
//   The finished word sits in an output register; the next sample is accepted
//   while it waits, and the program holds at its last step if the receiver
//   still stalls when the next word is ready.
//   Reset (i_rst_n low, synchronous) clears count, mean, variance and the
//   output valid flag.
module running_mean_variance_top #(
    parameter int COUNT_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // [15:0] sample
    input  logic         s_axis_tuser,   // [0] restart
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata    // [31:0] mean_value, [81:32] variance_value,
                                         // [97:82] sample_count, [103:98] zero
);
    import rmv_pkg::*;

    t_ctl ctl;
    t_sts sts;

    rmv_seq #(
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_ctl      (ctl)
    );

    rmv_dp #(
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_sample    (s_axis_tdata),
        .i_restart   (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

endmodule
